// ===== sv/crc32w_pkg.sv =====
// ----------------------------------------------------------------------------
// crc32w_pkg
// Shared types, constants and the word-wide CRC update for the CRC-32 core.
// ----------------------------------------------------------------------------
package crc32w_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CRC_W  = 32;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [WORD_W-1:0] data_word;
    logic              last_word;
  } item_t;

  // Head of the queue as seen by the back end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  // Write side of the queue, driven by the front end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_push_t;

  // MSB-first CRC over one word. Linear in crc and word, so the unrolled
  // steps collapse into a flat XOR network per output bit.
  function automatic logic [CRC_W-1:0] absorb_word(logic [CRC_W-1:0] crc,
                                                   logic [WORD_W-1:0] word);
    logic [CRC_W-1:0] c;
    logic             fb;
    c = crc;
    for (int n = WORD_W - 1; n >= 0; n--) begin
      fb = c[CRC_W-1] ^ word[n];
      c  = {c[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
    end
    return c;
  endfunction

endpackage

// ===== sv/crc32w_if.sv =====
// ----------------------------------------------------------------------------
// crc32w_if
// Valid/ready channels for message words in and finished CRC values out.
// ----------------------------------------------------------------------------
interface crc32w_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic        last_word;

  modport source (output valid, output data_word, output last_word, input ready);
  modport sink   (input valid, input data_word, input last_word, output ready);
endinterface

interface crc32w_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] crc_value;

  modport source (output valid, output crc_value, input ready);
  modport sink   (input valid, input crc_value, output ready);
endinterface

// ===== sv/crc32w_front.sv =====
// ----------------------------------------------------------------------------
// crc32w_front
// Input stage: registers each word with its end-of-message flag and hands
// it to the queue.
// ----------------------------------------------------------------------------
module crc32w_front (
  input  logic                clk,
  input  logic                rst,
  crc32w_in_if.sink           in_ch,
  input  logic                full,
  output crc32w_pkg::q_push_t push
);

  logic               stage_valid;
  crc32w_pkg::item_t  stage;

  assign push.valid  = stage_valid && !full;
  assign push.item   = stage;
  assign in_ch.ready = !stage_valid || !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ch.ready) begin
      stage_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      stage.data_word <= in_ch.data_word;
      stage.last_word <= in_ch.last_word;
    end
  end

endmodule

// ===== sv/crc32w_fifo.sv =====
// ----------------------------------------------------------------------------
// crc32w_fifo
// Short queue between the input stage and the CRC engine.
// ----------------------------------------------------------------------------
module crc32w_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  crc32w_pkg::q_push_t push,
  input  logic                pop,
  output logic                full,
  output crc32w_pkg::q_head_t head
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  crc32w_pkg::item_t mem [DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;

  assign full       = (count == CW'(DEPTH));
  assign head.valid = (count != '0);
  assign head.item  = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push.valid && !pop) begin
      count_next = count + CW'(1);
    end else if (pop && !push.valid) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push.valid) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.item;
    end
  end

endmodule

// ===== sv/crc32w_back.sv =====
// ----------------------------------------------------------------------------
// crc32w_back
// CRC engine: folds one word per cycle into the running CRC (a last word
// waits for a free output register) and registers each message's result.
// ----------------------------------------------------------------------------
module crc32w_back (
  input  logic                clk,
  input  logic                rst,
  input  crc32w_pkg::q_head_t head,
  output logic                pop,
  crc32w_out_if.source        out_ch
);

  logic [crc32w_pkg::CRC_W-1:0] running_crc;
  logic [crc32w_pkg::CRC_W-1:0] crc_next;
  logic                         out_valid;
  logic [crc32w_pkg::CRC_W-1:0] out_crc;

  assign crc_next = crc32w_pkg::absorb_word(running_crc, head.item.data_word);

  // A last word needs the output register free (or emptying this cycle).
  assign pop = head.valid && (!head.item.last_word || !out_valid || out_ch.ready);

  assign out_ch.valid     = out_valid;
  assign out_ch.crc_value = out_crc;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= crc32w_pkg::CRC_INIT;
      out_valid   <= 1'b0;
    end else begin
      if (pop && head.item.last_word) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (head.item.last_word) begin
          running_crc <= crc32w_pkg::CRC_INIT;
        end else begin
          running_crc <= crc_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.item.last_word) begin
      out_crc <= crc_next;
    end
  end

endmodule

// ===== sv/crc32_word_checksum_core.sv =====
// ----------------------------------------------------------------------------
// crc32_word_checksum_core
// CRC-32 (poly 0x04C11DB7, init all ones, MSB first, no final XOR) over
// messages of 32-bit words; one CRC value per message.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while the output does not hold back a last
//   word; the queue lets input and output stall independently.
// Path: a word passes the input stage register and the queue; the CRC is then registered at the output.
// Reset (synchronous, rst high): queue empty, no result pending, running
//   CRC back to all ones.
module crc32_word_checksum_core #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  crc32w_in_if.sink     in_ch,
  crc32w_out_if.source  out_ch
);

  crc32w_pkg::q_push_t push;
  crc32w_pkg::q_head_t head;
  logic                full;
  logic                pop;

  crc32w_front u_front (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .full  (full),
    .push  (push)
  );

  crc32w_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (full),
    .head (head)
  );

  crc32w_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(push.valid && full))
    else $error("queue written while full");

  a_no_last_over_stall: assert property (@(posedge clk) disable iff (rst)
    !(pop && head.item.last_word && out_ch.valid && !out_ch.ready))
    else $error("result overwritten while output stalled");

  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("pop from empty queue");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_ch.valid)
    else $error("result pending after reset");

endmodule
